// ===== hw/rtl/pac_pkg.sv =====
// ----------------------------------------------------------------------------
// pac_pkg: shared types and constants for the pixel compositor
// Command codes, blend modes and the stage records that travel down the
// compositor pipeline.
// ----------------------------------------------------------------------------
package pac_pkg;

    // Command codes of a request
    typedef enum logic [1:0] {
        CMD_TEXT = 2'd0,
        CMD_OVER = 2'd1,
        CMD_FILL = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    // What the last stage does with a pixel
    typedef enum logic [1:0] {
        MODE_PASS  = 2'd0,
        MODE_SOLID = 2'd1,
        MODE_BLEND = 2'd2
    } t_mode;

    localparam logic [7:0]  FULL       = 8'hFF;
    localparam logic [15:0] HALF       = 16'd127;
    localparam logic [7:0]  OPAQUE     = 8'hFF;
    // floor(s/3) == (s*683)>>11 for every s up to 766
    localparam logic [19:0] COV_RECIP  = 20'd683;
    localparam int          COV_SHIFT  = 11;
    localparam int          NUM_CHAN   = 3;

    // After weight selection
    typedef struct packed {
        logic        valid;
        t_mode       mode;
        logic [7:0]  weight;
        logic [23:0] fg;
        logic [23:0] rgb;
        logic [31:0] dst;
    } t_s1;

    // After per-channel products
    typedef struct packed {
        logic                           valid;
        t_mode                          mode;
        logic [NUM_CHAN-1:0][15:0]      num;
        logic [23:0]                    rgb;
        logic [31:0]                    dst;
    } t_s2;

endpackage

// ===== hw/rtl/pac_weight.sv =====
// ----------------------------------------------------------------------------
// pac_weight: first stage of the compositor
// Decodes the command, forms the mean subpixel coverage and picks the blend
// weight, foreground color and additive color for each request.
// ----------------------------------------------------------------------------
module pac_weight (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [1:0]    i_cmd,
    input  logic [31:0]   i_dest_pixel,
    input  logic [31:0]   i_source_pixel,
    input  logic [7:0]    i_subpixel_red,
    input  logic [7:0]    i_subpixel_green,
    input  logic [7:0]    i_subpixel_blue,
    input  logic [23:0]   i_paint_color,
    output pac_pkg::t_s1  o_s1
);
    import pac_pkg::*;

    logic [9:0]  cov_sum;
    logic [19:0] cov_prod;
    logic [7:0]  cov;
    logic [7:0]  src_alpha;
    t_mode       n_mode;
    logic [7:0]  n_weight;
    logic [23:0] n_fg;
    logic [23:0] n_rgb;
    t_s1         r_s1;

    // Rounded mean of the three coverage bytes, divide by three via reciprocal
    assign cov_sum  = {2'b00, i_subpixel_red} + {2'b00, i_subpixel_green}
                    + {2'b00, i_subpixel_blue} + 10'd1;
    assign cov_prod = {10'd0, cov_sum} * COV_RECIP;
    assign cov      = cov_prod[COV_SHIFT+7:COV_SHIFT];
    assign src_alpha = i_source_pixel[31:24];

    // Decode command into a mode and blend operands
    always_comb begin
        n_mode   = MODE_PASS;
        n_weight = '0;
        n_fg     = '0;
        n_rgb    = '0;
        case (t_cmd'(i_cmd))
            CMD_TEXT: begin
                if (cov == FULL) begin
                    n_mode = MODE_SOLID;
                    n_rgb  = i_paint_color;
                end else if (cov != 8'd0) begin
                    n_mode   = MODE_BLEND;
                    n_weight = cov;
                    n_fg     = i_paint_color;
                end
            end
            CMD_OVER: begin
                if (src_alpha == FULL) begin
                    n_mode = MODE_SOLID;
                    n_rgb  = i_source_pixel[23:0];
                end else if (src_alpha != 8'd0) begin
                    n_mode   = MODE_BLEND;
                    n_weight = src_alpha;
                    n_rgb    = i_source_pixel[23:0];
                end
            end
            CMD_FILL: begin
                n_mode = MODE_SOLID;
                n_rgb  = i_paint_color;
            end
            default: begin
                n_mode = MODE_PASS;
            end
        endcase
    end

    // Advance valid under reset, payload free-running
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1.valid <= i_valid;
        end
        r_s1.mode   <= n_mode;
        r_s1.weight <= n_weight;
        r_s1.fg     <= n_fg;
        r_s1.rgb    <= n_rgb;
        r_s1.dst    <= i_dest_pixel;
    end

    assign o_s1 = r_s1;

endmodule

// ===== hw/rtl/pac_mix.sv =====
// ----------------------------------------------------------------------------
// pac_mix: second stage of the compositor
// Forms fg*w + dst*(255-w) + 127 for each color channel.
// ----------------------------------------------------------------------------
module pac_mix (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pac_pkg::t_s1  i_s1,
    output pac_pkg::t_s2  o_s2
);
    import pac_pkg::*;

    logic [7:0]                inv;
    logic [NUM_CHAN-1:0][15:0] n_num;
    t_s2                       r_s2;

    assign inv = FULL - i_s1.weight;

    // One multiply-add lane per channel
    for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_lane
        logic [7:0] fg_ch;
        logic [7:0] dst_ch;
        assign fg_ch  = i_s1.fg[ch*8 +: 8];
        assign dst_ch = i_s1.dst[ch*8 +: 8];
        assign n_num[ch] = ({8'd0, fg_ch} * {8'd0, i_s1.weight})
                         + ({8'd0, dst_ch} * {8'd0, inv}) + HALF;
    end

    // Advance stage record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2.valid <= i_s1.valid;
        end
        r_s2.mode <= i_s1.mode;
        r_s2.num  <= n_num;
        r_s2.rgb  <= i_s1.rgb;
        r_s2.dst  <= i_s1.dst;
    end

    assign o_s2 = r_s2;

endmodule

// ===== hw/rtl/pac_norm.sv =====
// ----------------------------------------------------------------------------
// pac_norm: last stage of the compositor
// Divides each channel sum by 255, adds the source color with saturation and
// selects the final pixel into the output register.
// ----------------------------------------------------------------------------
module pac_norm (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pac_pkg::t_s2  i_s2,
    output logic [31:0]   o_result_pixel,
    output logic          o_pixel_changed,
    output logic          o_result_valid
);
    import pac_pkg::*;

    logic [23:0] mix_rgb;
    logic [31:0] n_pixel;
    logic        n_changed;
    logic [31:0] r_pixel;
    logic        r_changed;
    logic        r_valid;

    // Exact n/255 for n below 65280, then saturating add
    for (genvar ch = 0; ch < NUM_CHAN; ch++) begin : g_lane
        logic [16:0] div_t;
        logic [7:0]  quo;
        logic [8:0]  sum;
        assign div_t = {1'b0, i_s2.num[ch]} + 17'd1 + {9'd0, i_s2.num[ch][15:8]};
        assign quo   = div_t[15:8];
        assign sum   = {1'b0, i_s2.rgb[ch*8 +: 8]} + {1'b0, quo};
        assign mix_rgb[ch*8 +: 8] = sum[8] ? FULL : sum[7:0];
    end

    // Select the written pixel
    always_comb begin
        case (i_s2.mode)
            MODE_SOLID: begin
                n_pixel   = {OPAQUE, i_s2.rgb};
                n_changed = 1'b1;
            end
            MODE_BLEND: begin
                n_pixel   = {OPAQUE, mix_rgb};
                n_changed = 1'b1;
            end
            default: begin
                n_pixel   = i_s2.dst;
                n_changed = 1'b0;
            end
        endcase
    end

    // Hold the result for its strobe cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_s2.valid;
        end
        r_pixel   <= n_pixel;
        r_changed <= n_changed;
    end

    assign o_result_pixel  = r_pixel;
    assign o_pixel_changed = r_changed;
    assign o_result_valid  = r_valid;

endmodule

// ===== hw/rtl/pixel_alpha_compositor.sv =====
// ----------------------------------------------------------------------------
// pixel_alpha_compositor: per-pixel ARGB compositor
// Text coverage blend, premultiplied source-over and opaque fill on 32-bit
// 0xAARRGGBB pixels, one pixel per clock.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: raise start with i_cmd, i_dest_pixel, i_source_pixel and
//   the three subpixel coverage bytes; the request is taken on any clock edge
//   with start high and busy low. busy stays low, so a request can be issued
//   every cycle.
//   Result channel: o_result_valid strobes for one cycle with o_result_pixel
//   and o_pixel_changed. The receiver cannot stall; results must be taken in
//   the strobe cycle.
//   Throughput is one pixel per cycle. A request passes three register
//   stages on its way to the strobe: weight select, per-channel
//   multiply-add, divide-by-255 and output select.
//   Paint color: write i_cfg_data with i_cfg_we high while no request is in
//   flight; it is used by text blend and fill.
//   Reset (i_rst_n low, synchronous) empties the pipeline and clears the
//   paint color to black.
// ----------------------------------------------------------------------------
module pixel_alpha_compositor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_dest_pixel,
    input  logic [31:0] i_source_pixel,
    input  logic [7:0]  i_subpixel_red,
    input  logic [7:0]  i_subpixel_green,
    input  logic [7:0]  i_subpixel_blue,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_data,
    output logic [31:0] o_result_pixel,
    output logic        o_pixel_changed,
    output logic        o_result_valid
);
    import pac_pkg::*;

    logic [23:0] r_paint_color;
    logic [23:0] n_paint_color;
    t_s1         s1;
    t_s2         s2;

    // Pipeline never stalls
    assign busy = 1'b0;

    // Paint color register
    assign n_paint_color = i_cfg_we ? i_cfg_data : r_paint_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paint_color <= '0;
        end else begin
            r_paint_color <= n_paint_color;
        end
    end

    pac_weight u_weight (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (start & ~busy),
        .i_cmd           (i_cmd),
        .i_dest_pixel    (i_dest_pixel),
        .i_source_pixel  (i_source_pixel),
        .i_subpixel_red  (i_subpixel_red),
        .i_subpixel_green(i_subpixel_green),
        .i_subpixel_blue (i_subpixel_blue),
        .i_paint_color   (r_paint_color),
        .o_s1            (s1)
    );

    pac_mix u_mix (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_s1   (s1),
        .o_s2   (s2)
    );

    pac_norm u_norm (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s2           (s2),
        .o_result_pixel (o_result_pixel),
        .o_pixel_changed(o_pixel_changed),
        .o_result_valid (o_result_valid)
    );

    // Every request yields exactly one strobe, after the weight, mix and norm registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(i_rst_n, 2) && $past(i_rst_n, 3))
        |-> (o_result_valid == $past(start, 3)))
        else $error("result strobe does not follow request by three cycles");

    // An unchanged pixel is the destination that came in
    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_pixel_changed
         && $past(i_rst_n) && $past(i_rst_n, 2) && $past(i_rst_n, 3))
        |-> (o_result_pixel == $past(i_dest_pixel, 3)))
        else $error("unchanged pixel differs from its destination");

    // A written pixel is always opaque
    a_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_pixel_changed) |-> (o_result_pixel[31:24] == OPAQUE))
        else $error("written pixel is not opaque");

    // Fill writes the paint color
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(start, 3) && ($past(i_cmd, 3) == CMD_FILL)
         && $past(i_rst_n) && $past(i_rst_n, 2) && $past(i_rst_n, 3)
         && !$past(i_cfg_we) && !$past(i_cfg_we, 2) && !$past(i_cfg_we, 3))
        |-> (o_pixel_changed && o_result_pixel == {OPAQUE, r_paint_color}))
        else $error("fill did not write the paint color");

endmodule
